@@ rtl/mts_pkg.sv @@
`timescale 1ns / 1ps
package mts_pkg;

	localparam int DEPTH   = 16;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = 5;
	localparam int DATA_W  = 32;
	localparam int CAP_W   = 5;
	localparam int STAT_W  = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_W   = PADDR_W - 2;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam logic [REG_W-1:0] REG_CAPACITY = REG_W'(0);

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic rd_latch;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic pop_go;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/min_tracking_stack.sv @@
`timescale 1ns / 1ps
// Stack of signed 32-bit values that also tracks the minimum of everything stored.
// Input channel (in_valid/in_ready): one beat is a push (kind 0, push_value)
// or a pop (kind 1). Output channel (out_valid/out_ready): every input beat
// gives exactly one result beat with the popped value, the minimum after
// the operation, min_valid, entry_count and status (ok, full, empty).
// A refused push or pop leaves the stack unchanged and returns popped 0.
// APB port: register 0 at byte address 0 is capacity, the full limit,
// saturating at 16 entries; write it only while the block is idle.
// A push or a refused operation goes from the execute state to the result load
// state, where out_valid rises; a pop also passes the store read state between.
// The controller walks these states for each beat and then returns to idle;
// only in idle does it accept a new beat, so one beat is handled at a time.
// A result waiting in the output register does not block the next input
// beat; only the following result load waits while out_ready is low.
// Reset empties the stack, sets capacity to 16 and drops any pending result.
module min_tracking_stack
	import mts_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] popped_value,
	output logic signed [DATA_W-1:0] current_min,
	output logic                     min_valid,
	output logic [CNT_W-1:0]         entry_count,
	output logic [STAT_W-1:0]        status
);

	logic [CAP_W-1:0] capacity;
	dp_cmd_t          cmd;
	dp_stat_t         stat;

	mts_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	mts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.capacity     (capacity),
		.kind         (kind),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.popped_value (popped_value),
		.current_min  (current_min),
		.min_valid    (min_valid),
		.entry_count  (entry_count),
		.status       (status)
	);

endmodule

@@ rtl/mts_regs.sv @@
`timescale 1ns / 1ps
module mts_regs
	import mts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [CAP_W-1:0]   capacity
);

	logic [CAP_W-1:0] capacity_q;
	logic [REG_W-1:0] reg_idx;
	logic             wr_en;

	assign reg_idx  = paddr[PADDR_W-1:2];
	assign pready   = 1'b1;
	assign wr_en    = psel & penable & pwrite & pready & (reg_idx == REG_CAPACITY);
	assign capacity = capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (wr_en) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_CAPACITY) begin
			prdata = PDATA_W'(capacity_q);
		end
	end

endmodule

@@ rtl/mts_ctrl.sv @@
`timescale 1ns / 1ps
module mts_ctrl
	import mts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = stat.pop_go ? ST_READ : ST_EMIT;
			end
			ST_READ: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_READ: begin
				cmd.rd_latch = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/mts_dp.sv @@
`timescale 1ns / 1ps
module mts_dp
	import mts_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic [CAP_W-1:0]         capacity,
	input  logic                     kind,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] popped_value,
	output logic signed [DATA_W-1:0] current_min,
	output logic                     min_valid,
	output logic [CNT_W-1:0]         entry_count,
	output logic [STAT_W-1:0]        status
);

	logic signed [DATA_W-1:0] val_mem [DEPTH];
	logic signed [DATA_W-1:0] min_mem [DEPTH];

	logic                     kind_q;
	logic signed [DATA_W-1:0] value_q;
	logic [CNT_W-1:0]         fill_q;
	logic signed [DATA_W-1:0] cur_min_q;
	logic signed [DATA_W-1:0] popped_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] rd_val_q;
	logic signed [DATA_W-1:0] rd_min_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_popped_q;
	logic signed [DATA_W-1:0] out_min_q;
	logic                     out_min_valid_q;
	logic [CNT_W-1:0]         out_count_q;
	logic [STAT_W-1:0]        out_status_q;

	logic [CNT_W-1:0]         limit;
	logic                     full;
	logic                     nonempty;
	logic signed [DATA_W-1:0] push_min;
	logic                     push_wr;
	logic                     pop_rd;
	logic [CNT_W-1:0]         fill_m1;
	logic [CNT_W-1:0]         fill_m2;
	logic [ADDR_W-1:0]        wr_addr;
	logic [ADDR_W-1:0]        val_addr;
	logic [ADDR_W-1:0]        min_addr;

	assign limit    = (CNT_W'(capacity) > DEPTH_CNT) ? DEPTH_CNT : CNT_W'(capacity);
	assign full     = (fill_q >= limit) || (fill_q >= DEPTH_CNT);
	assign nonempty = (fill_q != '0);
	assign push_min = (nonempty && (cur_min_q < value_q)) ? cur_min_q : value_q;
	assign push_wr  = cmd.exec && (kind_q == KIND_PUSH) && !full;
	assign pop_rd   = cmd.exec && stat.pop_go;
	assign fill_m1  = fill_q - CNT_W'(1);
	assign fill_m2  = fill_q - CNT_W'(2);
	assign wr_addr  = fill_q[ADDR_W-1:0];
	assign val_addr = fill_m1[ADDR_W-1:0];
	assign min_addr = fill_m2[ADDR_W-1:0];

	assign stat.pop_go   = (kind_q == KIND_POP) && nonempty;
	assign stat.out_free = !out_valid_q || out_ready;

	// stack storage, registered read port
	always_ff @(posedge clk) begin
		if (push_wr) begin
			val_mem[wr_addr] <= value_q;
			min_mem[wr_addr] <= push_min;
		end
		if (pop_rd) begin
			rd_val_q <= val_mem[val_addr];
			rd_min_q <= min_mem[min_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.exec) begin
			if (push_wr) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (stat.pop_go) begin
				fill_q <= fill_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			value_q <= push_value;
		end
		if (cmd.exec) begin
			popped_q <= '0;
			status_q <= STAT_OK;
			if (kind_q == KIND_PUSH) begin
				if (full) begin
					status_q <= STAT_FULL;
				end else begin
					cur_min_q <= push_min;
				end
			end else if (!nonempty) begin
				status_q <= STAT_EMPTY;
			end
		end
		if (cmd.rd_latch) begin
			popped_q  <= rd_val_q;
			cur_min_q <= rd_min_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_popped_q    <= popped_q;
			out_min_q       <= nonempty ? cur_min_q : '0;
			out_min_valid_q <= nonempty;
			out_count_q     <= fill_q;
			out_status_q    <= status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = out_popped_q;
	assign current_min  = out_min_q;
	assign min_valid    = out_min_valid_q;
	assign entry_count  = out_count_q;
	assign status       = out_status_q;

endmodule

@@ rtl/mts_checker.sv @@
`timescale 1ns / 1ps
module mts_checker
	import mts_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [DATA_W-1:0] popped_value,
	input logic signed [DATA_W-1:0] current_min,
	input logic                     min_valid,
	input logic [CNT_W-1:0]         entry_count,
	input logic [STAT_W-1:0]        status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
		else $error("result beat dropped or changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= DEPTH_CNT)
		else $error("entry count beyond depth");

	a_min_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (min_valid == (entry_count != '0)) && (min_valid || current_min == '0))
		else $error("minimum validity disagrees with entry count");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_FULL || status == STAT_EMPTY) |-> popped_value == '0)
		else $error("refused operation returned a value");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> entry_count == '0)
		else $error("empty refusal with entries stored");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import mts_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] popped;
		logic [DATA_W-1:0] min_value;
		logic              nonempty;
		logic [CNT_W-1:0]  count;
		logic [STAT_W-1:0] stat;
	} stack_result_t;

	typedef struct packed {
		logic              is_cap_write;
		logic [CAP_W-1:0]  cap;
		logic              op;
		logic [DATA_W-1:0] value;
		logic              typed;
		stack_result_t     want;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [PADDR_W-1:0]       paddr = '0;
	logic [PDATA_W-1:0]       pwdata = '0;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     kind = 1'b0;
	logic signed [DATA_W-1:0] push_value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] popped_value;
	logic signed [DATA_W-1:0] current_min;
	logic                     min_valid;
	logic [CNT_W-1:0]         entry_count;
	logic [STAT_W-1:0]        status;

	logic signed [DATA_W-1:0] shadow_values [DEPTH];
	logic signed [DATA_W-1:0] shadow_mins [DEPTH];
	int                       shadow_fill = 0;
	int                       shadow_cap = 16;

	stack_result_t pending_results [$];
	stim_row_t     directed_rows [$];
	stack_result_t want_beat, got_beat;
	int            mismatch_count = 0;
	logic          idle_on = 1'b1;
	logic          hold_req = 1'b0;
	logic          hold_done = 1'b0;
	int            hold_left = 0;
	int            stall_left = 0;

	min_tracking_stack uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.popped_value(popped_value),
		.current_min(current_min),
		.min_valid(min_valid),
		.entry_count(entry_count),
		.status(status)
	);

	always #2 clk = ~clk;

	function automatic stack_result_t mk_result(input logic [DATA_W-1:0] popped,
			input logic [DATA_W-1:0] min_value, input logic nonempty,
			input int count, input logic [STAT_W-1:0] stat);
		stack_result_t r;
		r.popped = popped;
		r.min_value = min_value;
		r.nonempty = nonempty;
		r.count = CNT_W'(count);
		r.stat = stat;
		return r;
	endfunction

	function automatic stack_result_t apply_stack_op(input logic op,
			input logic signed [DATA_W-1:0] value);
		stack_result_t r;
		int limit;
		logic signed [DATA_W-1:0] m;
		r = '0;
		r.stat = STAT_OK;
		limit = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
		if (op == KIND_PUSH) begin
			if (shadow_fill >= limit) begin
				r.stat = STAT_FULL;
			end else begin
				m = value;
				if (shadow_fill > 0 && shadow_mins[shadow_fill-1] < m) begin
					m = shadow_mins[shadow_fill-1];
				end
				shadow_values[shadow_fill] = value;
				shadow_mins[shadow_fill] = m;
				shadow_fill++;
			end
		end else if (shadow_fill == 0) begin
			r.stat = STAT_EMPTY;
		end else begin
			shadow_fill--;
			r.popped = shadow_values[shadow_fill];
		end
		if (shadow_fill > 0) begin
			r.min_value = shadow_mins[shadow_fill-1];
		end
		r.nonempty = (shadow_fill > 0);
		r.count = CNT_W'(shadow_fill);
		return r;
	endfunction

	task automatic add_op(input logic op, input logic [DATA_W-1:0] value);
		stim_row_t row;
		row = '0;
		row.op = op;
		row.value = value;
		directed_rows.push_back(row);
	endtask

	task automatic add_typed(input logic op, input logic [DATA_W-1:0] value,
			input stack_result_t want);
		stim_row_t row;
		row = '0;
		row.op = op;
		row.value = value;
		row.typed = 1'b1;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	task automatic add_cap(input logic [CAP_W-1:0] cap);
		stim_row_t row;
		row = '0;
		row.is_cap_write = 1'b1;
		row.cap = cap;
		directed_rows.push_back(row);
	endtask

	task automatic send_beat(input logic op, input logic [DATA_W-1:0] value,
			input logic typed, input stack_result_t want);
		stack_result_t predicted;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		push_value <= value;
		do @(posedge clk); while (!in_ready);
		predicted = apply_stack_op(op, value);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		logic [PDATA_W-1:0] word;
		word = $urandom;
		word[CAP_W-1:0] = cap;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(REG_CAPACITY) << 2;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[CAP_W-1:0] !== cap) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("capacity readback: expected %0d, got %0d", cap,
					prdata[CAP_W-1:0]);
			end
		end
		psel <= 1'b0;
		penable <= 1'b0;
		shadow_cap = cap;
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			got_beat = {popped_value, current_min, min_valid, entry_count, status};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected beat: popped %h min %h valid %b count %0d status %0d",
						got_beat.popped, got_beat.min_value, got_beat.nonempty,
						got_beat.count, got_beat.stat);
				end
			end else begin
				want_beat = pending_results.pop_front();
				if (got_beat !== want_beat) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("beat mismatch: popped %h/%h min %h/%h valid %b/%b count %0d/%0d status %0d/%0d (expected/actual)",
							want_beat.popped, got_beat.popped,
							want_beat.min_value, got_beat.min_value,
							want_beat.nonempty, got_beat.nonempty,
							want_beat.count, got_beat.count,
							want_beat.stat, got_beat.stat);
					end
				end
			end
		end
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 3) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

	initial begin
		int phase_caps [10];
		int i, j, n_items, seg_left;
		logic push_heavy;
		logic op;
		logic [CAP_W-1:0] cap;
		logic [DATA_W-1:0] value;
		stim_row_t row;

		phase_caps = '{31, 16, 0, 3, 1, 17, 8, 0, 0, 16};

		add_typed(KIND_POP, 32'h0, mk_result(0, 0, 1'b0, 0, STAT_EMPTY));
		add_typed(KIND_PUSH, 32'h7fff_ffff, mk_result(0, 32'h7fff_ffff, 1'b1, 1, STAT_OK));
		add_typed(KIND_PUSH, 32'h8000_0000, mk_result(0, 32'h8000_0000, 1'b1, 2, STAT_OK));
		add_typed(KIND_PUSH, 32'h0, mk_result(0, 32'h8000_0000, 1'b1, 3, STAT_OK));
		add_op(KIND_PUSH, 32'hffff_ffff);
		add_op(KIND_POP, 32'hffff_ffff);
		add_op(KIND_POP, 32'h0);
		add_op(KIND_POP, 32'h1234_5678);
		add_typed(KIND_POP, 32'h0, mk_result(32'h7fff_ffff, 0, 1'b0, 0, STAT_OK));
		add_typed(KIND_POP, 32'h0, mk_result(0, 0, 1'b0, 0, STAT_EMPTY));
		add_cap(0);
		add_typed(KIND_PUSH, 32'h1234_5678, mk_result(0, 0, 1'b0, 0, STAT_FULL));
		add_typed(KIND_POP, 32'h0, mk_result(0, 0, 1'b0, 0, STAT_EMPTY));
		add_cap(2);
		add_op(KIND_PUSH, 32'd5);
		add_op(KIND_PUSH, 32'd3);
		add_typed(KIND_PUSH, 32'd1, mk_result(0, 3, 1'b1, 2, STAT_FULL));
		add_cap(1);
		add_typed(KIND_PUSH, 32'd9, mk_result(0, 3, 1'b1, 2, STAT_FULL));
		add_op(KIND_POP, 32'h0);
		add_typed(KIND_PUSH, 32'd2, mk_result(0, 5, 1'b1, 1, STAT_FULL));
		add_op(KIND_POP, 32'h0);
		add_typed(KIND_POP, 32'h0, mk_result(0, 0, 1'b0, 0, STAT_EMPTY));
		add_cap(31);
		add_op(KIND_PUSH, 32'haaaa_aaaa);
		add_op(KIND_PUSH, 32'h5555_5555);
		add_op(KIND_POP, 32'h0);
		add_op(KIND_POP, 32'h0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			row = directed_rows[k];
			if (row.is_cap_write) begin
				settle();
				write_capacity(row.cap);
			end else begin
				send_beat(row.op, row.value, row.typed, row.want);
			end
		end

		for (i = 0; i < 10; i++) begin
			settle();
			cap = (i == 7 || i == 8) ? CAP_W'($urandom_range(0, 31)) : CAP_W'(phase_caps[i]);
			write_capacity(cap);
			idle_on = (i != 5 && i != 9);
			n_items = (cap == 0) ? 40 : 205;
			seg_left = 0;
			push_heavy = 1'b0;
			for (j = 0; j < n_items; j++) begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(4, 40);
					push_heavy = !push_heavy;
				end
				seg_left--;
				if ($urandom_range(0, 99) < 85) begin
					op = push_heavy ? KIND_PUSH : KIND_POP;
				end else begin
					op = push_heavy ? KIND_POP : KIND_PUSH;
				end
				case ($urandom_range(0, 7))
					0: value = 32'h8000_0000;
					1: value = 32'h7fff_ffff;
					2, 3: value = DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
					default: value = $urandom;
				endcase
				if (i == 1 && j == 50) begin
					hold_req <= 1'b1;
				end
				if (i == 3 && j == 120) begin
					settle();
				end
				send_beat(op, value, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
